### src/cqa_pkg.sv
package cqa_pkg;

   localparam int CONNS      = 64;
   localparam int PARTITIONS = 16;

   localparam int MODE_W  = 2;
   localparam int CONN_W  = 10;
   localparam int PART_W  = 8;
   localparam int QUOTA_W = 16;
   localparam int COUNT_W = 16;

   localparam int SLOT_AW = (CONNS > 1) ? $clog2(CONNS) : 1;
   localparam int PART_AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

   localparam logic [CONN_W:0] CONNS_LIM      = (CONN_W + 1)'(CONNS);
   localparam logic [PART_W:0] PARTITIONS_LIM = (PART_W + 1)'(PARTITIONS);

   localparam logic [COUNT_W-1:0] OUT_OF_RANGE = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_ATTRIBUTE = 2'd0,
      MODE_RELEASE   = 2'd1,
      MODE_SET_QUOTA = 2'd2,
      MODE_QUERY     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_MODIFY,
      ST_READ,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [QUOTA_W-1:0] quota;
   } part_entry_type;

endpackage

### src/cqa_req_if.sv
interface cqa_req_if;
   import cqa_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [CONN_W-1:0]  conn_index;
   logic [PART_W-1:0]  partition_index;
   logic [QUOTA_W-1:0] quota_value;

   modport source (output valid, mode, conn_index, partition_index, quota_value,
                   input ready);
   modport sink   (input valid, mode, conn_index, partition_index, quota_value,
                   output ready);
endinterface

### src/cqa_rsp_if.sv
interface cqa_rsp_if;
   import cqa_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic [COUNT_W-1:0] usage;
   logic [QUOTA_W-1:0] limit;

   modport source (output valid, accepted, usage, limit, input ready);
   modport sink   (input valid, accepted, usage, limit, output ready);
endinterface

### src/connection_quota_admission.sv
// Per-partition connection admission. Each request word on req_chan carries
// a mode (attribute, release, set quota, query), a connection slot, a
// partition and a quota; each one produces exactly one response word on
// rsp_chan with the accepted flag and the addressed partition's usage and
// limit after the operation (both 65535 for a partition out of range).
// The slot-owner table and the per-partition count/quota table sit in two
// single-port-read RAMs with a registered read. An item walks a
// fixed sequence: read the slot, read the partition to modify, write back,
// read the partition to report, register the response. The response
// register is loaded at the end of that sequence, and no new request is
// taken until the item has left the report step; the two dependent RAM
// reads and the write-back before the report read set that sequence.
// req_chan.ready is high only between items and low during reset.
// The response sits in an output register: if rsp_chan stalls, the next
// request is still taken and processed, and its result waits in the
// report step until the register frees up.
// Reset is synchronous: it clears the per-entry valid flags, so every slot
// reads as unattributed and every partition as count 0, quota 0
// (unlimited) in the first cycle after reset, with no clearing pass.
module connection_quota_admission (
   input  logic     clock,
   input  logic     reset,
   cqa_req_if.sink   req_chan,
   cqa_rsp_if.source rsp_chan
);
   import cqa_pkg::*;

   state_type state_ff, state_in;

   logic [MODE_W-1:0]  mode_ff;
   logic [CONN_W-1:0]  conn_ff;
   logic [PART_W-1:0]  part_ff;
   logic [QUOTA_W-1:0] quota_ff;
   logic [PART_AW-1:0] pend_addr_ff, pend_addr_in;

   logic [CONNS-1:0]      slot_valid_ff, slot_valid_in;
   logic [PARTITIONS-1:0] part_valid_ff, part_valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff;
   logic [COUNT_W-1:0] rsp_usage_ff;
   logic [QUOTA_W-1:0] rsp_limit_ff;

   logic               req_take;
   logic               slot_ok;
   logic               part_ok;
   logic               owner_valid;
   logic [SLOT_AW-1:0] slot_addr;
   logic [PART_AW-1:0] part_addr;
   mode_type           mode;

   logic               slot_we;
   logic [PART_AW-1:0] slot_rdata;

   logic               part_we;
   logic               part_re;
   logic [PART_AW-1:0] part_raddr;
   part_entry_type     part_wdata;
   part_entry_type     part_rdata;
   part_entry_type     entry;

   logic               acc;
   logic               rsp_load;

   assign req_take  = req_chan.valid && req_chan.ready;
   assign mode      = mode_type'(mode_ff);
   assign slot_addr = conn_ff[SLOT_AW-1:0];
   assign part_addr = part_ff[PART_AW-1:0];
   assign slot_ok   = {1'b0, conn_ff} < CONNS_LIM;
   assign part_ok   = {1'b0, part_ff} < PARTITIONS_LIM;
   assign owner_valid = slot_ok && slot_valid_ff[slot_addr];

   // an entry never written reads as count 0, quota 0
   assign entry = part_valid_ff[pend_addr_ff] ? part_rdata : '0;

   cqa_ram #(.WIDTH(PART_AW), .DEPTH(CONNS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_addr),
      .wr_data (part_addr),
      .rd_en   (req_take),
      .rd_addr (req_chan.conn_index[SLOT_AW-1:0]),
      .rd_data (slot_rdata)
   );

   cqa_ram #(.WIDTH($bits(part_entry_type)), .DEPTH(PARTITIONS)) u_part_ram (
      .clock   (clock),
      .wr_en   (part_we),
      .wr_addr (pend_addr_ff),
      .wr_data (part_wdata),
      .rd_en   (part_re),
      .rd_addr (part_raddr),
      .rd_data (part_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      pend_addr_in  = pend_addr_ff;
      slot_valid_in = slot_valid_ff;
      part_valid_in = part_valid_ff;
      slot_we       = 1'b0;
      part_we       = 1'b0;
      part_re       = 1'b0;
      part_raddr    = part_addr;
      part_wdata    = entry;
      acc           = 1'b0;
      rsp_load      = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !reset;
            if (req_chan.valid) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            // release touches the owner's count, the others the given partition
            part_re = 1'b1;
            if (mode == MODE_RELEASE) begin
               part_raddr = slot_rdata;
            end
            pend_addr_in = part_raddr;
            state_in     = ST_MODIFY;
         end
         ST_MODIFY: begin
            case (mode)
               MODE_ATTRIBUTE: begin
                  if (owner_valid) begin
                     acc = 1'b1;
                  end else if (slot_ok && part_ok &&
                               !(entry.quota != '0 && entry.count >= entry.quota)) begin
                     acc     = 1'b1;
                     slot_we = 1'b1;
                     part_we = 1'b1;
                     slot_valid_in[slot_addr] = 1'b1;
                     if (entry.count != COUNT_MAX) begin
                        part_wdata.count = entry.count + COUNT_W'(1);
                     end
                  end
               end
               MODE_RELEASE: begin
                  if (owner_valid) begin
                     acc     = 1'b1;
                     part_we = 1'b1;
                     slot_valid_in[slot_addr] = 1'b0;
                     if (entry.count != '0) begin
                        part_wdata.count = entry.count - COUNT_W'(1);
                     end
                  end
               end
               MODE_SET_QUOTA: begin
                  if (part_ok) begin
                     acc     = 1'b1;
                     part_we = 1'b1;
                     part_wdata.quota = quota_ff;
                  end
               end
               default: begin
                  acc = part_ok;
               end
            endcase
            if (part_we) begin
               part_valid_in[pend_addr_ff] = 1'b1;
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            // read after the write-back lands, so the report sees the update
            part_re      = 1'b1;
            pend_addr_in = part_addr;
            state_in     = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         part_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         part_valid_ff <= part_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   logic acc_ff;

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (req_take) begin
         mode_ff  <= req_chan.mode;
         conn_ff  <= req_chan.conn_index;
         part_ff  <= req_chan.partition_index;
         quota_ff <= req_chan.quota_value;
      end
      if (state_ff == ST_MODIFY) begin
         acc_ff <= acc;
      end
      if (rsp_load) begin
         rsp_accepted_ff <= acc_ff;
         rsp_usage_ff    <= part_ok ? entry.count : OUT_OF_RANGE;
         rsp_limit_ff    <= part_ok ? entry.quota : OUT_OF_RANGE;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.accepted = rsp_accepted_ff;
   assign rsp_chan.usage    = rsp_usage_ff;
   assign rsp_chan.limit    = rsp_limit_ff;

endmodule

### src/cqa_ram.sv
module cqa_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### src/cqa_checker.sv
module cqa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_accepted,
   input logic [cqa_pkg::COUNT_W-1:0] rsp_usage,
   input logic [cqa_pkg::QUOTA_W-1:0] rsp_limit
);

   // hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_accepted) && $stable(rsp_usage) && $stable(rsp_limit))
      else $error("response payload changed while stalled");

   // one item at a time: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a response rising into an empty output register must trace back to a taken request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 5))
      else $error("response without a request five cycles earlier");

endmodule

bind connection_quota_admission cqa_checker u_cqa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_accepted (rsp_chan.accepted),
   .rsp_usage    (rsp_chan.usage),
   .rsp_limit    (rsp_chan.limit)
);
